FILE: rtl/core/affine_2d_transform_unit_top_assert.svh
// assertion macros for the affine transform core
`ifndef AFFINE_2D_TRANSFORM_UNIT_TOP_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define AFF2D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aff2d assertion failed");
`define AFF2D_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("aff2d assertion failed");
`else
`define AFF2D_ASSERT(lbl, clk, rst_n, prop)
`define AFF2D_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/aff2d_pkg.sv
package aff2d_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int ARG_BITS  = 32;
    localparam int OPD_BITS  = (WORD_BITS > ARG_BITS) ? WORD_BITS : ARG_BITS;
    localparam int PROD_BITS = 2 * OPD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int SHR_BITS  = SUM_BITS - FRAC_BITS;
    localparam int MAT_SIZE  = 9;

    typedef logic [2:0] t_cmd_code;

    typedef enum logic [2:0] {
        CMD_IDENTITY  = 3'd0,
        CMD_TRANSLATE = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_ROTATE    = 3'd3,
        CMD_POINT     = 3'd4
    } t_cmd;

    typedef logic signed [ARG_BITS-1:0]  t_arg;
    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [OPD_BITS-1:0]  t_opd;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [SUM_BITS-1:0]  t_sum;
    typedef logic signed [SHR_BITS-1:0]  t_shr;
    typedef t_word [MAT_SIZE-1:0]        t_matrix;

    localparam t_opd  ONE_OPD   = t_opd'(1) <<< FRAC_BITS;
    localparam t_word WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_arg  ARG_MAX   = {1'b0, {(ARG_BITS-1){1'b1}}};
    localparam t_arg  ARG_MIN   = {1'b1, {(ARG_BITS-1){1'b0}}};
    // unit value, clipped when the word cannot hold it
    localparam t_word UNIT_WORD = (FRAC_BITS >= WORD_BITS - 1) ? WORD_MAX : t_word'(ONE_OPD);

    // round half up, drop fraction bits, clip to the word range
    function automatic t_word round_sat(t_sum s);
        t_sum rnd;
        t_shr q;
        rnd = s + (t_sum'(1) <<< (FRAC_BITS - 1));
        q   = t_shr'(rnd >>> FRAC_BITS);
        if (q > t_shr'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (q < t_shr'(WORD_MIN)) begin
            return WORD_MIN;
        end else begin
            return t_word'(q);
        end
    endfunction

    function automatic t_word dot3(t_opd a0, t_opd b0, t_opd a1, t_opd b1,
                                   t_opd a2, t_opd b2);
        t_prod p0;
        t_prod p1;
        t_prod p2;
        p0 = t_prod'(a0) * t_prod'(b0);
        p1 = t_prod'(a1) * t_prod'(b1);
        p2 = t_prod'(a2) * t_prod'(b2);
        return round_sat(t_sum'(p0) + t_sum'(p1) + t_sum'(p2));
    endfunction

    // point results go out on the fixed 32-bit field
    function automatic t_arg word_to_arg(t_word w);
        t_opd wide;
        wide = t_opd'(w);
        if (WORD_BITS <= ARG_BITS) begin
            return t_arg'(wide);
        end else if (wide > t_opd'(ARG_MAX)) begin
            return ARG_MAX;
        end else if (wide < t_opd'(ARG_MIN)) begin
            return ARG_MIN;
        end else begin
            return t_arg'(wide);
        end
    endfunction

endpackage

FILE: rtl/core/aff2d_ifs.sv
interface aff2d_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    aff2d_pkg::t_arg   arg_a;
    aff2d_pkg::t_arg   arg_b;
    aff2d_pkg::t_arg   arg_c;
    aff2d_pkg::t_arg   arg_d;

    modport source (output valid, cmd, arg_a, arg_b, arg_c, arg_d, input ready);
    modport sink   (input valid, cmd, arg_a, arg_b, arg_c, arg_d, output ready);
endinterface

interface aff2d_result_if;
    logic              valid;
    logic              ready;
    aff2d_pkg::t_arg   out_x;
    aff2d_pkg::t_arg   out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface

FILE: rtl/core/affine_2d_transform_unit_top.sv
// 2d affine transform core, 3x3 row-vector matrix in signed Q16.16.
// i_item: valid/ready channel carrying cmd and arg_a..arg_d. identity,
// translate, scale and rotate-by-basis rewrite the held matrix; transform
// point maps (arg_a, arg_b) through it and is the only word that produces
// a result on o_result (out_x, out_y). unused cmd codes are consumed silently.
// throughput: one word per cycle for any mix of commands while o_result does not
// stall. each word sits in an input register while 27 parallel 32x32 multipliers
// feed three-term adders, rounding and saturation into the matrix and the output
// register; that path also sets the clock. a point result moves from the input
// to the output register. a matrix command is in effect for the very next word.
// reset (i_rst_n low, synchronous) clears the matrix to zero and empties both
// stages. when o_result stalls, the output register holds its word and one
// more word is taken into the input register; a point word there waits and
// i_item.ready drops until the output frees, matrix commands keep moving.
`include "affine_2d_transform_unit_top_assert.svh"

module affine_2d_transform_unit_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aff2d_item_if.sink      i_item,
    aff2d_result_if.source  o_result
);
    import aff2d_pkg::*;

    logic      r_in_valid;
    t_cmd_code r_cmd;
    t_arg      r_arg_a;
    t_arg      r_arg_b;
    t_arg      r_arg_c;
    t_arg      r_arg_d;
    t_matrix   r_mat;
    logic      r_out_valid;
    t_arg      r_out_x;
    t_arg      r_out_y;

    t_matrix   n_mat;
    t_arg      n_out_x;
    t_arg      n_out_y;

    logic      is_point;
    logic      is_update;
    logic      out_free;
    logic      adv;

    t_opd      bm  [MAT_SIZE];
    t_opd      u_a [MAT_SIZE][3];
    t_opd      u_b [MAT_SIZE][3];
    t_word     res [MAT_SIZE];

    assign is_point  = (r_cmd == CMD_POINT);
    assign is_update = (r_cmd == CMD_IDENTITY) || (r_cmd == CMD_TRANSLATE) ||
                       (r_cmd == CMD_SCALE) || (r_cmd == CMD_ROTATE);
    assign out_free  = !r_out_valid || o_result.ready;
    assign adv       = r_in_valid && (!is_point || out_free);

    assign i_item.ready   = !r_in_valid || adv;
    assign o_result.valid = r_out_valid;
    assign o_result.out_x = r_out_x;
    assign o_result.out_y = r_out_y;

    // right-hand matrix built from the arguments
    always_comb begin
        for (int k = 0; k < MAT_SIZE; k++) begin
            bm[k] = '0;
        end
        bm[8] = ONE_OPD;
        unique case (r_cmd)
            CMD_TRANSLATE: begin
                bm[0] = ONE_OPD;
                bm[4] = ONE_OPD;
                bm[6] = t_opd'(r_arg_a);
                bm[7] = t_opd'(r_arg_b);
            end
            CMD_SCALE: begin
                bm[0] = t_opd'(r_arg_a);
                bm[4] = t_opd'(r_arg_b);
            end
            CMD_ROTATE: begin
                bm[0] = t_opd'(r_arg_a);
                bm[1] = t_opd'(r_arg_b);
                bm[3] = t_opd'(r_arg_c);
                bm[4] = t_opd'(r_arg_d);
            end
            default: begin
                bm[8] = ONE_OPD;
            end
        endcase
    end

    // operand routing: row i by column j, units 0 and 1 reused for points
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    u_a[i*3+j][k] = t_opd'(r_mat[i*3+k]);
                    u_b[i*3+j][k] = bm[k*3+j];
                end
            end
        end
        if (is_point) begin
            for (int c = 0; c < 2; c++) begin
                u_a[c][0] = t_opd'(r_mat[c]);
                u_a[c][1] = t_opd'(r_mat[3+c]);
                u_a[c][2] = t_opd'(r_mat[6+c]);
                u_b[c][0] = t_opd'(r_arg_a);
                u_b[c][1] = t_opd'(r_arg_b);
                u_b[c][2] = ONE_OPD;
            end
        end
    end

    always_comb begin
        for (int u = 0; u < MAT_SIZE; u++) begin
            res[u] = dot3(u_a[u][0], u_b[u][0], u_a[u][1], u_b[u][1],
                          u_a[u][2], u_b[u][2]);
        end
    end

    always_comb begin
        n_mat   = r_mat;
        n_out_x = word_to_arg(res[0]);
        n_out_y = word_to_arg(res[1]);
        unique case (r_cmd) inside
            CMD_IDENTITY: begin
                for (int k = 0; k < MAT_SIZE; k++) begin
                    n_mat[k] = (k % 4 == 0) ? UNIT_WORD : '0;
                end
            end
            CMD_TRANSLATE, CMD_SCALE, CMD_ROTATE: begin
                for (int k = 0; k < MAT_SIZE; k++) begin
                    n_mat[k] = res[k];
                end
            end
            default: begin
                n_mat = r_mat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mat       <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (adv) begin
                r_mat <= n_mat;
            end
            if (adv && is_point) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_cmd   <= i_item.cmd;
            r_arg_a <= i_item.arg_a;
            r_arg_b <= i_item.arg_b;
            r_arg_c <= i_item.arg_c;
            r_arg_d <= i_item.arg_d;
        end
        if (adv && is_point) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    `AFF2D_ASSERT_NORST(a_reset_empties, i_clk, !i_rst_n |=> !r_in_valid && !r_out_valid)
    `AFF2D_ASSERT(a_out_from_point, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(adv && is_point))
    `AFF2D_ASSERT(a_point_waits, i_clk, i_rst_n,
        r_in_valid && is_point && r_out_valid && !o_result.ready |-> !i_item.ready)
    `AFF2D_ASSERT(a_matrix_hold, i_clk, i_rst_n, !(adv && is_update) |=> $stable(r_mat))
    `AFF2D_ASSERT(a_identity_load, i_clk, i_rst_n,
        adv && r_cmd == CMD_IDENTITY |=> {r_mat[8], r_mat[4], r_mat[0]} == {3{UNIT_WORD}})

endmodule

FILE: tb/sv/affine_2d_transform_unit_checker.sv
`timescale 1ns / 100ps

module affine_2d_transform_unit_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    aff2d_item_if   i_item,
    aff2d_result_if i_result,
    output int      o_fail_count,
    output int      o_outstanding
);
    import aff2d_pkg::*;

    typedef struct packed {
        t_arg x;
        t_arg y;
    } t_point;

    localparam t_word FX_UNIT = t_word'(1) <<< FRAC_BITS;

    t_word  xform [MAT_SIZE];
    t_point point_q [$];
    int     mismatches = 0;

    // exact three-term sum, round half up, drop the fraction, clip to the word
    function automatic t_word fx_dot3(t_word a0, t_word b0, t_word a1, t_word b1,
                                      t_word a2, t_word b2);
        logic signed [2*WORD_BITS+1:0] acc;
        acc = a0 * b0 + a1 * b1 + a2 * b2 + (1 <<< (FRAC_BITS - 1));
        acc = acc >>> FRAC_BITS;
        if (acc > WORD_MAX) begin
            return WORD_MAX;
        end else if (acc < WORD_MIN) begin
            return WORD_MIN;
        end
        return t_word'(acc);
    endfunction

    // xform <= xform * bm, row-vector convention
    task automatic post_multiply(input t_word bm [MAT_SIZE]);
        t_word nxt [MAT_SIZE];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                nxt[r*3+c] = fx_dot3(xform[r*3], bm[c], xform[r*3+1], bm[3+c],
                                     xform[r*3+2], bm[6+c]);
            end
        end
        xform = nxt;
    endtask

    task automatic predict_word(input t_cmd_code code, input t_arg a, input t_arg b,
                                input t_arg c, input t_arg d);
        t_word  bm [MAT_SIZE];
        t_point pt;
        case (t_cmd'(code))
            CMD_IDENTITY: begin
                for (int k = 0; k < MAT_SIZE; k++) begin
                    xform[k] = (k % 4 == 0) ? FX_UNIT : '0;
                end
            end
            CMD_TRANSLATE: begin
                bm = '{FX_UNIT, '0, '0, '0, FX_UNIT, '0, a, b, FX_UNIT};
                post_multiply(bm);
            end
            CMD_SCALE: begin
                bm = '{a, '0, '0, '0, b, '0, '0, '0, FX_UNIT};
                post_multiply(bm);
            end
            CMD_ROTATE: begin
                bm = '{a, b, '0, c, d, '0, '0, '0, FX_UNIT};
                post_multiply(bm);
            end
            CMD_POINT: begin
                pt.x = fx_dot3(xform[0], a, xform[3], b, xform[6], FX_UNIT);
                pt.y = fx_dot3(xform[1], a, xform[4], b, xform[7], FX_UNIT);
                point_q.push_back(pt);
            end
            default: begin
                // spare codes are swallowed
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAT_SIZE; k++) begin
                xform[k] = '0;
            end
            point_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (point_q.size() == 0) begin
                    $display("%0t: unexpected point word, expected none actual x=%h y=%h",
                             $time, i_result.out_x, i_result.out_y);
                    mismatches++;
                end else begin
                    want = point_q.pop_front();
                    if (i_result.out_x !== want.x) begin
                        $display("%0t: out_x mismatch, expected %h actual %h",
                                 $time, want.x, i_result.out_x);
                        mismatches++;
                    end
                    if (i_result.out_y !== want.y) begin
                        $display("%0t: out_y mismatch, expected %h actual %h",
                                 $time, want.y, i_result.out_y);
                        mismatches++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                predict_word(i_item.cmd, i_item.arg_a, i_item.arg_b, i_item.arg_c,
                             i_item.arg_d);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= point_q.size();
    end

endmodule

FILE: tb/sv/affine_2d_transform_unit_top_tb.sv
`timescale 1ns / 100ps

module affine_2d_transform_unit_top_tb;
    import aff2d_pkg::*;

    localparam t_arg      FX_ONE           = 32'sd65536;
    localparam t_arg      FX_HALF          = 32'sd32768;
    localparam int        SMALL_SPAN       = 8 * 65536;
    localparam t_cmd_code FIRST_SPARE_CMD  = 3'd5;
    localparam t_cmd_code LAST_SPARE_CMD   = 3'd7;
    localparam int        WORDS_PER_PHASE  = 225;
    localparam int        HOLD_CYCLES      = 300;
    localparam int        CYCLE_LIMIT      = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aff2d_item_if   item_ch ();
    aff2d_result_if result_ch ();

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_flip    = 1'b0;
    int   cycle_cnt    = 0;
    int   fail_cnt;
    int   outstanding;

    affine_2d_transform_unit_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    affine_2d_transform_unit_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_cnt),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever hold_flip toggles
    initial begin
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic t_arg pick_arg();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            return t_arg'($urandom);
        end else if (sel < 30) begin
            case ($urandom_range(4))
                0: return ARG_MAX;
                1: return ARG_MIN;
                2: return '0;
                3: return FX_ONE;
                default: return -FX_ONE;
            endcase
        end
        return t_arg'($urandom_range(2 * SMALL_SPAN, 0)) - SMALL_SPAN;
    endfunction

    task automatic send_word(input t_cmd_code code, input t_arg a, input t_arg b,
                             input t_arg c, input t_arg d);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= code;
        item_ch.arg_a <= a;
        item_ch.arg_b <= b;
        item_ch.arg_c <= c;
        item_ch.arg_d <= d;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // mostly points on a matrix that keeps changing; spare codes are not counted
    task automatic send_random_word(output bit counted);
        int unsigned pick;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 58) begin
            send_word(CMD_POINT, pick_arg(), pick_arg(), $urandom, $urandom);
        end else if (pick < 66) begin
            send_word(CMD_IDENTITY, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 76) begin
            send_word(CMD_TRANSLATE, pick_arg(), pick_arg(), $urandom, $urandom);
        end else if (pick < 84) begin
            send_word(CMD_SCALE, pick_arg(), pick_arg(), $urandom, $urandom);
        end else if (pick < 94) begin
            send_word(CMD_ROTATE, pick_arg(), pick_arg(), pick_arg(), pick_arg());
        end else begin
            send_word(t_cmd_code'($urandom_range(LAST_SPARE_CMD, FIRST_SPARE_CMD)),
                      $urandom, $urandom, $urandom, $urandom);
            counted = 1'b0;
        end
    endtask

    initial begin
        bit counted;
        int sent;
        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.cmd   <= '0;
        item_ch.arg_a <= '0;
        item_ch.arg_b <= '0;
        item_ch.arg_c <= '0;
        item_ch.arg_d <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero matrix after reset, spare codes, extremes, rounding, saturation
        send_word(CMD_POINT, FX_ONE, FX_ONE, '0, '0);
        for (int k = FIRST_SPARE_CMD; k <= LAST_SPARE_CMD; k++) begin
            send_word(t_cmd_code'(k), ARG_MAX, ARG_MIN, ARG_MAX, ARG_MIN);
        end
        send_word(CMD_IDENTITY, '0, '0, '0, '0);
        send_word(CMD_POINT, ARG_MAX, ARG_MIN, '0, '0);
        send_word(CMD_POINT, '0, '0, '1, '1);
        send_word(CMD_TRANSLATE, ARG_MAX, ARG_MIN, '0, '0);
        send_word(CMD_POINT, ARG_MAX, ARG_MAX, '0, '0);
        send_word(CMD_POINT, ARG_MIN, ARG_MIN, '0, '0);
        send_word(CMD_IDENTITY, '0, '0, '0, '0);
        // half-way products round toward plus infinity
        send_word(CMD_SCALE, FX_HALF, -FX_ONE, '0, '0);
        send_word(CMD_POINT, 32'sd1, 32'sd1, '0, '0);
        send_word(CMD_POINT, -32'sd1, -32'sd1, '0, '0);
        send_word(CMD_ROTATE, '0, FX_ONE, -FX_ONE, '0);
        send_word(CMD_POINT, FX_ONE * 3, FX_ONE * 2, '0, '0);
        send_word(CMD_SCALE, ARG_MAX, ARG_MIN, '0, '0);
        send_word(CMD_POINT, ARG_MIN, ARG_MAX, '0, '0);
        send_word(CMD_ROTATE, ARG_MIN, ARG_MIN, ARG_MAX, ARG_MAX);
        send_word(CMD_POINT, FX_ONE, -FX_ONE, '0, '0);
        send_word(CMD_IDENTITY, '0, '0, '0, '0);
        send_word(CMD_TRANSLATE, FX_ONE * 5, -FX_ONE * 7, '0, '0);
        send_word(CMD_POINT, '0, '0, '0, '0);

        // long receiver hold-off while words keep coming, fills the pipe
        hold_flip <= ~hold_flip;
        for (int k = 0; k < 40; k++) begin
            send_random_word(counted);
        end

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 25 : 0;
            rx_stall_pct <= (ph == 2) ? 50 : (ph == 3) ? 25 : 0;
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                send_random_word(counted);
                if (counted) begin
                    sent++;
                end
            end
        end
        item_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
